/* sv/assert_macros.svh */
// Assertion macros shared by the filter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* sv/udf_pkg.sv */
// Shared types and constants for the UDP destination filter.
// No dependencies; imported by every filter module.
`timescale 1ns / 1ps

package udf_pkg;

  localparam logic [15:0] TAG_8021Q  = 16'h8100;
  localparam logic [15:0] TAG_8021AD = 16'h88A8;
  localparam logic [15:0] TYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [3:0]  IP_VERSION = 4'd4;
  localparam logic [3:0]  IHL_MIN    = 4'd5;

  localparam logic [6:0] ETH_HDR_LEN = 7'd14;
  localparam logic [6:0] TAGGED_LEN  = 7'd18;
  localparam logic [6:0] IP_MIN_LEN  = 7'd20;
  localparam logic [6:0] UDP_HDR_LEN = 7'd8;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT    = 2'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic [6:0]  payload_offset;
    logic [15:0] payload_length;
    logic [31:0] frames_seen;
    logic [31:0] frames_matched;
    logic [31:0] bytes_matched;
  } out_item_t;

  // Header fields captured over one frame, handed from parser to checker.
  typedef struct packed {
    logic [15:0] cap_len;
    logic [15:0] outer_type;
    logic [15:0] inner_type;
    logic [3:0]  header_words;
    logic [3:0]  version;
    logic [7:0]  protocol;
    logic [31:0] dst_address;
    logic [15:0] udp_dport;
    logic [15:0] udp_length;
  } frame_rec_t;

endpackage

/* sv/udp_destination_filter_core.sv */
// Top level of the UDP destination filter: parser, record queue, checker.
// Depends on udf_pkg, udf_front, udf_queue and udf_back.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | in_item_t (one frame byte)
//   out_    | output    | out_valid / out_stall| out_item_t (one per frame)
//   cfg_    | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
// One byte is taken per cycle unless stalled; out_valid is a registered output.
// Frame ends may come every cycle; a four-entry record queue decouples the parser.
// in_stall rises only while that queue is full; out_stall back-pressures the checker.
// Synchronous active-low reset clears counters, position, latches and registers.
`timescale 1ns / 1ps

module udp_destination_filter_core import udf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  logic       rec_push;
  frame_rec_t rec_data;
  logic       q_full, q_empty, q_pop;
  frame_rec_t q_head;

  assign in_stall = q_full;

  udf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .rec_push (rec_push),
    .rec_data (rec_data)
  );

  udf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (rec_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  udf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* sv/udf_front.sv */
// Byte parser: tracks position and latches Ethernet/VLAN/IPv4/UDP fields.
// Depends on udf_pkg; pushes one frame_rec_t per frame end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module udf_front import udf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  output logic       rec_push,
  output frame_rec_t rec_data
);

  logic [15:0] pos_r, pos_nxt, pos_inc;
  logic [15:0] outer_r, outer_nxt;
  logic [15:0] inner_r, inner_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [3:0]  ver_r, ver_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] port_r, port_nxt;
  logic [15:0] ulen_r, ulen_nxt;

  logic        accept;
  logic        is_vlan;
  logic [15:0] base16;
  logic [15:0] udp16;
  logic [7:0]  b;

  assign accept = in_valid && !in_stall;
  assign b      = in_data.data_byte;
  assign is_vlan = (outer_r == TAG_8021Q) || (outer_r == TAG_8021AD);
  assign base16 = {9'd0, (is_vlan ? TAGGED_LEN : ETH_HDR_LEN)};
  assign udp16  = base16 + {10'd0, hw_r, 2'b00};
  assign pos_inc = (pos_r != POS_MAX) ? pos_r + 16'd1 : pos_r;

  always_comb begin
    outer_nxt = outer_r;
    inner_nxt = inner_r;
    hw_nxt    = hw_r;
    ver_nxt   = ver_r;
    proto_nxt = proto_r;
    addr_nxt  = addr_r;
    port_nxt  = port_r;
    ulen_nxt  = ulen_r;
    if (pos_r == 16'd12 || pos_r == 16'd13) begin
      outer_nxt = {outer_r[7:0], b};
    end
    if (pos_r == 16'd16 || pos_r == 16'd17) begin
      inner_nxt = {inner_r[7:0], b};
    end
    if (pos_r >= {9'd0, ETH_HDR_LEN}) begin
      if (pos_r == base16) begin
        ver_nxt = b[7:4];
        hw_nxt  = b[3:0];
      end
      if (pos_r == base16 + 16'd9) begin
        proto_nxt = b;
      end
      if (pos_r >= base16 + 16'd16 && pos_r <= base16 + 16'd19) begin
        addr_nxt = {addr_r[23:0], b};
      end
      if (pos_r > base16) begin
        if (pos_r == udp16 + 16'd2 || pos_r == udp16 + 16'd3) begin
          port_nxt = {port_r[7:0], b};
        end
        if (pos_r == udp16 + 16'd4 || pos_r == udp16 + 16'd5) begin
          ulen_nxt = {ulen_r[7:0], b};
        end
      end
    end
    pos_nxt = in_data.frame_end ? 16'd0 : pos_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      outer_r <= '0;
      inner_r <= '0;
      hw_r    <= '0;
      ver_r   <= '0;
      proto_r <= '0;
      addr_r  <= '0;
      port_r  <= '0;
      ulen_r  <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      outer_r <= outer_nxt;
      inner_r <= inner_nxt;
      hw_r    <= hw_nxt;
      ver_r   <= ver_nxt;
      proto_r <= proto_nxt;
      addr_r  <= addr_nxt;
      port_r  <= port_nxt;
      ulen_r  <= ulen_nxt;
    end
  end

  assign rec_push = accept && in_data.frame_end;

  always_comb begin
    rec_data.cap_len      = pos_inc;
    rec_data.outer_type   = outer_nxt;
    rec_data.inner_type   = inner_nxt;
    rec_data.header_words = hw_nxt;
    rec_data.version      = ver_nxt;
    rec_data.protocol     = proto_nxt;
    rec_data.dst_address  = addr_nxt;
    rec_data.udp_dport    = port_nxt;
    rec_data.udp_length   = ulen_nxt;
  end

  `ASSERT_NEXT(a_pos_clear, clk, rst_n, rec_push, pos_r == 16'd0)
  `ASSERT_IMPLIES(a_cap_nonzero, clk, rst_n, rec_push, rec_data.cap_len != 16'd0)
  `ASSERT_NEXT(a_pos_hold, clk, rst_n, !accept, pos_r == $past(pos_r))

endmodule

/* sv/udf_queue.sv */
// Short FIFO of per-frame header records between parser and checker.
// Depends on udf_pkg for frame_rec_t and QUEUE_DEPTH.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module udf_queue import udf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_rec_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output frame_rec_t head
);

  frame_rec_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]       count_r, count_nxt;
  logic                    do_push, do_pop;

  assign full    = count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
  `ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, count_r <= (QUEUE_AW + 1)'(QUEUE_DEPTH))

endmodule

/* sv/udf_back.sv */
// Frame checker and statistics: filters each record, keeps running counters.
// Depends on udf_pkg; holds the destination address and port registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module udf_back import udf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 q_empty,
  input  frame_rec_t           q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  logic [31:0] dst_address_r;
  logic [15:0] dport_r;

  // check stage
  logic        chk_valid_r;
  logic        chk_matched_r, chk_matched_nxt;
  logic [6:0]  chk_off_r, chk_off_nxt;
  logic [15:0] chk_len_r, chk_len_nxt;

  // output stage
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [31:0] seen_r, match_r, sum_r;

  logic        chk_adv;
  logic        is_vlan;
  logic [15:0] l3_type;
  logic [6:0]  base, ihl, udp, off;
  logic [15:0] cap;
  logic [15:0] len_full;
  logic [16:0] frame_end_pos;
  logic        hdr_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_address_r <= '0;
      dport_r       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DST_ADDRESS: dst_address_r <= cfg_wdata;
        CFG_DST_PORT:    dport_r       <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign chk_adv = !out_valid_r || !out_stall;
  assign q_pop   = !q_empty && (!chk_valid_r || chk_adv);

  always_comb begin
    cap      = q_head.cap_len;
    is_vlan  = (q_head.outer_type == TAG_8021Q) || (q_head.outer_type == TAG_8021AD);
    l3_type  = is_vlan ? q_head.inner_type : q_head.outer_type;
    base     = is_vlan ? TAGGED_LEN : ETH_HDR_LEN;
    ihl      = {1'b0, q_head.header_words, 2'b00};
    udp      = base + ihl;
    off      = udp + UDP_HDR_LEN;
    len_full = q_head.udp_length - {9'd0, UDP_HDR_LEN};
    frame_end_pos = {10'd0, off} + {1'b0, len_full};
    hdr_ok = (cap >= {9'd0, ETH_HDR_LEN})
          && (!is_vlan || cap >= {9'd0, TAGGED_LEN})
          && (l3_type == TYPE_IPV4)
          && (cap >= {9'd0, base} + {9'd0, IP_MIN_LEN})
          && (q_head.version == IP_VERSION)
          && (q_head.header_words >= IHL_MIN)
          && (cap >= {9'd0, off})
          && (q_head.protocol == PROTO_UDP)
          && (q_head.dst_address == dst_address_r)
          && (q_head.udp_dport == dport_r)
          && (q_head.udp_length >= {9'd0, UDP_HDR_LEN});
    chk_matched_nxt = hdr_ok;
    chk_len_nxt     = len_full;
    if ({1'b0, cap} < frame_end_pos) begin
      if (cap > {9'd0, off}) begin
        chk_len_nxt = cap - {9'd0, off};
      end else begin
        chk_matched_nxt = 1'b0;
      end
    end
    chk_off_nxt = off;
    if (!chk_matched_nxt) begin
      chk_off_nxt = '0;
      chk_len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_valid_r <= 1'b0;
    end else if (q_pop) begin
      chk_valid_r <= 1'b1;
    end else if (chk_adv) begin
      chk_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      chk_matched_r <= chk_matched_nxt;
      chk_off_r     <= chk_off_nxt;
      chk_len_r     <= chk_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      match_r     <= '0;
      sum_r       <= '0;
    end else if (chk_adv) begin
      out_valid_r <= chk_valid_r;
      if (chk_valid_r) begin
        seen_r <= seen_r + 32'd1;
        if (chk_matched_r) begin
          match_r <= match_r + 32'd1;
          sum_r   <= sum_r + {16'd0, chk_len_r};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk_adv && chk_valid_r) begin
      out_data_r.matched        <= chk_matched_r;
      out_data_r.payload_offset <= chk_off_r;
      out_data_r.payload_length <= chk_len_r;
      out_data_r.frames_seen    <= seen_r + 32'd1;
      out_data_r.frames_matched <= match_r + {31'd0, chk_matched_r};
      out_data_r.bytes_matched  <= chk_matched_r ? sum_r + {16'd0, chk_len_r} : sum_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_unmatched_zero, clk, rst_n, out_valid_r && !out_data_r.matched,
    out_data_r.payload_offset == 7'd0 && out_data_r.payload_length == 16'd0)
  `ASSERT_IMPLIES(a_seen_tracks, clk, rst_n, out_valid_r, out_data_r.frames_seen == seen_r)
  `ASSERT_IMPLIES(a_matched_offset, clk, rst_n, chk_valid_r && chk_matched_r,
    chk_off_r >= ETH_HDR_LEN + IP_MIN_LEN + UDP_HDR_LEN)

endmodule

/* sim/tb_udp_destination_filter_core.sv */
// Self-checking testbench for udp_destination_filter_core: directed and random frames,
// one byte per transaction, checked against a scoreboard that re-parses each frame.
// Depends on udf_pkg and the filter RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_udp_destination_filter_core;
  import udf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;

  class udp_filter_scoreboard;
    logic [31:0] cfg_addr;
    logic [15:0] cfg_port;
    logic [15:0] byte_pos;
    logic [15:0] outer_type;
    logic [15:0] inner_type;
    logic [3:0]  ihl_seen;
    logic [3:0]  version_seen;
    logic [7:0]  proto_seen;
    logic [31:0] addr_seen;
    logic [15:0] port_seen;
    logic [15:0] udp_len_seen;
    logic [31:0] seen_cnt;
    logic [31:0] match_cnt;
    logic [31:0] byte_sum;
    out_item_t   expected_results[$];
    int          errors;

    function new();
      cfg_addr = '0; cfg_port = '0; byte_pos = '0; outer_type = '0; inner_type = '0;
      ihl_seen = '0; version_seen = '0; proto_seen = '0; addr_seen = '0;
      port_seen = '0; udp_len_seen = '0; seen_cnt = '0; match_cnt = '0; byte_sum = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      if (idx == CFG_DST_ADDRESS) cfg_addr = value;
      else if (idx == CFG_DST_PORT) cfg_port = value[15:0];
    endfunction

    function bit is_vlan();
      return outer_type == TAG_8021Q || outer_type == TAG_8021AD;
    endfunction

    function bit frame_ok(int cap, output int off, output int len);
      int base;
      int hdr;
      int udp_start;
      logic [15:0] ty;
      off = 0;
      len = 0;
      if (cap < int'(ETH_HDR_LEN)) return 0;
      base = int'(ETH_HDR_LEN);
      ty = outer_type;
      if (is_vlan()) begin
        if (cap < int'(TAGGED_LEN)) return 0;
        ty = inner_type;
        base = int'(TAGGED_LEN);
      end
      if (ty != TYPE_IPV4) return 0;
      if (cap < base + int'(IP_MIN_LEN)) return 0;
      if (version_seen != IP_VERSION) return 0;
      if (ihl_seen < IHL_MIN) return 0;
      hdr = int'(ihl_seen) * 4;
      if (cap < base + hdr) return 0;
      if (proto_seen != PROTO_UDP) return 0;
      udp_start = base + hdr;
      if (cap < udp_start + int'(UDP_HDR_LEN)) return 0;
      if (addr_seen != cfg_addr) return 0;
      if (port_seen != cfg_port) return 0;
      if (udp_len_seen < 16'(UDP_HDR_LEN)) return 0;
      off = udp_start + int'(UDP_HDR_LEN);
      len = int'(udp_len_seen) - int'(UDP_HDR_LEN);
      if (cap < off + len) begin
        if (cap > off) len = cap - off;
        else return 0;
      end
      return 1;
    endfunction

    function void note_byte(in_item_t item);
      int p;
      int base;
      int udp_start;
      int off;
      int len;
      bit ok;
      logic [7:0] b;
      out_item_t r;
      b = item.data_byte;
      p = int'(byte_pos);
      if (p == 12 || p == 13) outer_type = {outer_type[7:0], b};
      if (p == 16 || p == 17) inner_type = {inner_type[7:0], b};
      if (p >= int'(ETH_HDR_LEN)) begin
        base = is_vlan() ? int'(TAGGED_LEN) : int'(ETH_HDR_LEN);
        if (p == base) {version_seen, ihl_seen} = b;
        if (p == base + 9) proto_seen = b;
        if (p >= base + 16 && p <= base + 19) addr_seen = {addr_seen[23:0], b};
        udp_start = base + int'(ihl_seen) * 4;
        if (p > base) begin
          if (p == udp_start + 2 || p == udp_start + 3) port_seen = {port_seen[7:0], b};
          if (p == udp_start + 4 || p == udp_start + 5) udp_len_seen = {udp_len_seen[7:0], b};
        end
      end
      if (byte_pos != POS_MAX) byte_pos++;
      if (!item.frame_end) return;
      ok = frame_ok(int'(byte_pos), off, len);
      byte_pos = '0;
      seen_cnt++;
      if (ok) begin
        match_cnt++;
        byte_sum += 32'(len);
      end else begin
        off = 0;
        len = 0;
      end
      r.matched        = ok;
      r.payload_offset = 7'(off);
      r.payload_length = 16'(len);
      r.frames_seen    = seen_cnt;
      r.frames_matched = match_cnt;
      r.bytes_matched  = byte_sum;
      expected_results.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      cmp("matched", 32'(exp.matched), 32'(got.matched));
      cmp("payload_offset", 32'(exp.payload_offset), 32'(got.payload_offset));
      cmp("payload_length", 32'(exp.payload_length), 32'(got.payload_length));
      cmp("frames_seen", exp.frames_seen, got.frames_seen);
      cmp("frames_matched", exp.frames_matched, got.frames_matched);
      cmp("bytes_matched", exp.bytes_matched, got.bytes_matched);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  udp_filter_scoreboard sb;
  logic [7:0] frame_bytes[$];
  bit send_burst;
  bit hold_req;
  int bytes_sent;
  int frames_sent;

  udp_destination_filter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // result side: per-transaction stall draw, bursts with no stall, one long hold
  initial begin
    int stall_left;
    int results;
    bit recv_burst;
    stall_left = 0;
    results = 0;
    recv_burst = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
        results++;
        if (results % 8 == 0) recv_burst = ($urandom_range(0, 2) == 0);
        stall_left = recv_burst ? 0 : $urandom_range(0, 17);
      end
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic drive_byte(input logic [7:0] b, input bit last);
    int gap;
    in_item_t item;
    item.data_byte = b;
    item.frame_end = last;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_byte(item);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      drive_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  task automatic truncate_frame(input int n);
    if (n >= 1 && n < frame_bytes.size()) frame_bytes = frame_bytes[0:n-1];
  endtask

  task automatic build_frame(input bit vlan, input logic [15:0] tag, input logic [15:0] etype,
                             input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [31:0] addr,
                             input logic [15:0] port, input logic [15:0] ulen,
                             input int body);
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    if (vlan) begin
      frame_bytes.push_back(tag[15:8]);
      frame_bytes.push_back(tag[7:0]);
      repeat (2) frame_bytes.push_back(8'($urandom));
    end
    frame_bytes.push_back(etype[15:8]);
    frame_bytes.push_back(etype[7:0]);
    frame_bytes.push_back({ver, ihl});
    repeat (8) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(proto);
    repeat (6) frame_bytes.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(addr[8*i +: 8]);
    if (ihl > IHL_MIN) repeat ((int'(ihl) - 5) * 4) frame_bytes.push_back(8'($urandom));
    repeat (2) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(port[15:8]);
    frame_bytes.push_back(port[7:0]);
    frame_bytes.push_back(ulen[15:8]);
    frame_bytes.push_back(ulen[7:0]);
    repeat (2) frame_bytes.push_back(8'($urandom));
    repeat (body) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic good_frame(input bit vlan, input logic [15:0] tag, input logic [3:0] ihl,
                            input logic [15:0] ulen, input int body);
    build_frame(vlan, tag, TYPE_IPV4, IP_VERSION, ihl, PROTO_UDP, sb.cfg_addr, sb.cfg_port,
                ulen, body);
  endtask

  task automatic noise_frame(input int n, input bit all_ones);
    frame_bytes.delete();
    repeat (n) frame_bytes.push_back(all_ones ? 8'hFF : 8'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic set_filter(input logic [31:0] addr, input logic [15:0] port);
    write_reg(CFG_DST_ADDRESS, addr);
    write_reg(CFG_DST_PORT, {16'($urandom), port});
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_frame();
    int kind;
    int sel;
    int pay;
    int body;
    bit vlan;
    logic [15:0] tag;
    logic [15:0] etype;
    logic [3:0] ver;
    logic [3:0] ihl;
    logic [7:0] proto;
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] ulen;
    send_burst = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      noise_frame($urandom_range(1, 80), 1'b0);
    end else begin
      sel = $urandom_range(0, 3);
      vlan = (sel >= 2);
      tag = (sel == 2) ? TAG_8021Q : TAG_8021AD;
      etype = ($urandom_range(0, 11) == 0) ? 16'($urandom) : TYPE_IPV4;
      if (!vlan && $urandom_range(0, 15) == 0) etype = TAG_8021Q;
      ver = ($urandom_range(0, 9) == 0) ? 4'($urandom) : IP_VERSION;
      ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom) : IHL_MIN;
      proto = ($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_UDP;
      addr = sb.cfg_addr;
      if ($urandom_range(0, 9) == 0) addr = addr ^ (32'd1 << $urandom_range(0, 31));
      port = sb.cfg_port;
      if ($urandom_range(0, 9) == 0) port = port ^ (16'd1 << $urandom_range(0, 15));
      pay = $urandom_range(0, 24);
      ulen = 16'(pay + 8);
      sel = $urandom_range(0, 9);
      if (sel == 0) ulen = 16'($urandom);
      else if (sel == 1) ulen = 16'($urandom_range(0, 7));
      sel = $urandom_range(0, 5);
      if (sel == 0) body = pay + $urandom_range(1, 6);
      else if (sel == 1) body = $urandom_range(0, pay);
      else body = pay;
      build_frame(vlan, tag, etype, ver, ihl, proto, addr, port, ulen, body);
      if ($urandom_range(0, 7) == 0) truncate_frame($urandom_range(1, frame_bytes.size()));
    end
    send_frame();
  endtask

  task automatic random_phase(input int min_frames, input int min_bytes);
    int f0;
    int b0;
    f0 = frames_sent;
    b0 = bytes_sent;
    while (frames_sent - f0 < min_frames || bytes_sent - b0 < min_bytes) random_frame();
  endtask

  task automatic directed_frames();
    send_burst = 1'b0;
    good_frame(1'b0, 16'h0, IHL_MIN, 16'd8, 0);      send_frame();
    good_frame(1'b0, 16'h0, IHL_MIN, 16'd12, 0);     send_frame();
    good_frame(1'b0, 16'h0, IHL_MIN, 16'd20, 5);     send_frame();
    good_frame(1'b0, 16'h0, IHL_MIN, 16'd8, 3);      send_frame();
    good_frame(1'b1, TAG_8021Q, IHL_MIN, 16'd10, 2); send_frame();
    good_frame(1'b1, TAG_8021AD, 4'd15, 16'd12, 4);  send_frame();
    good_frame(1'b1, TAG_8021Q, IHL_MIN, 16'd10, 2); truncate_frame(17); send_frame();
    good_frame(1'b0, 16'h0, 4'd4, 16'd10, 2);        send_frame();
    good_frame(1'b0, 16'h0, 4'd0, 16'd10, 2);        send_frame();
    good_frame(1'b0, 16'h0, 4'd7, 16'd10, 2);        truncate_frame(40); send_frame();
    good_frame(1'b0, 16'h0, IHL_MIN, 16'd7, 2);      send_frame();
    good_frame(1'b0, 16'h0, IHL_MIN, 16'd10, 2);     truncate_frame(30); send_frame();
    build_frame(1'b0, 16'h0, TYPE_IPV4, 4'd6, IHL_MIN, PROTO_UDP, sb.cfg_addr, sb.cfg_port,
                16'd10, 2);
    send_frame();
    build_frame(1'b0, 16'h0, TYPE_IPV4, IP_VERSION, IHL_MIN, PROTO_TCP, sb.cfg_addr,
                sb.cfg_port, 16'd10, 2);
    send_frame();
    build_frame(1'b0, 16'h0, TYPE_IPV4, IP_VERSION, IHL_MIN, PROTO_UDP, ~sb.cfg_addr,
                sb.cfg_port, 16'd10, 2);
    send_frame();
    build_frame(1'b0, 16'h0, TYPE_IPV4, IP_VERSION, IHL_MIN, PROTO_UDP, sb.cfg_addr,
                ~sb.cfg_port, 16'd10, 2);
    send_frame();
    build_frame(1'b1, TAG_8021Q, TYPE_IPV6, IP_VERSION, IHL_MIN, PROTO_UDP, sb.cfg_addr,
                sb.cfg_port, 16'd10, 2);
    send_frame();
    noise_frame(1, 1'b0);   send_frame();
    noise_frame(13, 1'b0);  send_frame();
    good_frame(1'b0, 16'h0, IHL_MIN, 16'd10, 2); truncate_frame(14); send_frame();
    noise_frame(20, 1'b1);  send_frame();
    noise_frame(20, 1'b0);
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    send_frame();
    good_frame(1'b0, 16'h0, IHL_MIN, 16'd16, 8); send_frame();
  endtask

  initial begin
    sb = new();
    hold_req = 1'b0;
    send_burst = 1'b0;
    bytes_sent = 0;
    frames_sent = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_filter($urandom, 16'($urandom));
    directed_frames();
    wait_idle();

    set_filter(32'h0, 16'h0);
    random_phase(2, 40);
    wait_idle();

    set_filter(32'hFFFF_FFFF, 16'hFFFF);
    random_phase(2, 30);
    hold_req = 1'b1;
    send_burst = 1'b1;
    repeat (12) begin
      noise_frame($urandom_range(1, 3), 1'b0);
      send_frame();
    end
    random_phase(2, 30);
    wait_idle();

    repeat (2) begin
      set_filter($urandom, 16'($urandom));
      random_phase(2, 40);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* udp_destination_filter_core.f */
+incdir+sv
sv/udf_pkg.sv
sv/udf_front.sv
sv/udf_queue.sv
sv/udf_back.sv
sv/udp_destination_filter_core.sv
sim/tb_udp_destination_filter_core.sv
